// ===== sv/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg: shared types for the stable merge sorter
// Holds the command record that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int unsigned VALUE_W = 32;

  // One request from the front end: a value to store or an end-of-run marker.
  typedef struct packed {
    logic               is_last;
    logic               keep;      // value fits in the store
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_A,
    ST_RD_B,
    ST_MERGE,
    ST_ORD,
    ST_OUT
  } state_t;

endpackage

// ===== sv/sms_ram.sv =====
// ----------------------------------------------------------------------------
// sms_ram: generic simple dual-port RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sms_front.sv =====
// ----------------------------------------------------------------------------
// sms_front: input classifier and command queue
// Counts elements of a run, marks those past capacity, and queues requests.
// ----------------------------------------------------------------------------
module sms_front #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [31:0]   value,
  input  logic          last,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output sms_pkg::cmd_t cmd
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [CW-1:0]  count;
  sms_pkg::cmd_t  q [2];
  logic           wp, rp;
  logic [1:0]     fill;
  logic           acc;

  assign full      = (fill == 2'd2);
  assign acc       = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= 1'b0;
      rp    <= 1'b0;
      fill  <= 2'd0;
    end else begin
      if (acc) begin
        q[wp] <= '{is_last: last, keep: (count < CW'(MAX_ELEMENTS)), value: value};
        wp    <= ~wp;
        if (last) begin
          count <= '0;
        end else if (count < CW'(MAX_ELEMENTS)) begin
          count <= count + CW'(1);
        end
      end
      if (cmd_valid && cmd_take) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, acc} - {1'b0, cmd_valid && cmd_take};
    end
  end

endmodule

// ===== sv/sms_back.sv =====
// ----------------------------------------------------------------------------
// sms_back: storage, bottom-up merge engine and result queue
// Stores values, merges runs between two RAMs, then streams the sorted run.
// ----------------------------------------------------------------------------
module sms_back #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  sms_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   sorted_value,
  output logic          last_out,
  output logic          overflow
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  sms_pkg::state_t state, state_next;

  // Run bookkeeping: element count, pass width, the two run heads a and b,
  // the run bounds mid and hi, and the write position k.
  logic [CW-1:0] n, wid, a, b, mid, hi, k;
  logic          ovf;
  logic          src_sel;   // 1 when the current source run lives in scratch
  logic          took_a;    // previous merge step consumed the left run
  logic [31:0]   va, vb;

  logic          st_we, sc_we;
  logic [AW-1:0] st_wa, sc_wa, rd_addr;
  logic [31:0]   st_wd, st_rd, sc_rd, rd_data;

  logic [31:0]   cur_a, cur_b, win;
  logic          a_ok, b_ok, take_a;
  logic          pair_end, pass_end;
  logic [CW-1:0] n_total;
  logic [CW:0]   n_w, wid2, wid4, hi_wid, hi_wid2;
  logic [CW:0]   nx_mid, nx_hi, ps_mid, ps_hi;

  // Output register: one result slot.
  logic          ob_full;
  logic          emit;

  sms_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(rd_addr), .rdata(st_rd)
  );
  sms_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_scratch (
    .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(win), .raddr(rd_addr), .rdata(sc_rd)
  );

  assign n_total = n + CW'(cmd.keep);
  assign rd_data = src_sel ? sc_rd : st_rd;

  // The head of the run consumed last time arrives fresh from the RAM; the
  // other head is held in its register.
  assign cur_a  = took_a ? rd_data : va;
  assign cur_b  = took_a ? vb : rd_data;
  assign a_ok   = (a < mid);
  assign b_ok   = (b < hi);
  assign take_a = a_ok && (!b_ok || ($signed(cur_a) <= $signed(cur_b)));
  assign win    = take_a ? cur_a : cur_b;

  assign pair_end = (k + CW'(1) == hi);
  assign pass_end = (hi == n);

  assign n_w     = {1'b0, n};
  assign wid2    = {wid, 1'b0};
  assign wid4    = {wid2[CW-1:0], 1'b0};
  assign hi_wid  = {1'b0, hi} + {1'b0, wid};
  assign hi_wid2 = {1'b0, hi} + wid2;
  assign nx_mid  = (hi_wid > n_w) ? n_w : hi_wid;
  assign nx_hi   = (hi_wid2 > n_w) ? n_w : hi_wid2;
  assign ps_mid  = (wid2 > n_w) ? n_w : wid2;
  assign ps_hi   = (wid4 > n_w) ? n_w : wid4;

  assign sc_wa = AW'(k);
  assign empty = !ob_full;
  assign emit  = (state == sms_pkg::ST_OUT) && (!ob_full || pop);

  always_comb begin
    state_next = state;
    unique case (state)
      sms_pkg::ST_LOAD: if (cmd_valid && cmd.is_last) begin
        state_next = (n_total > CW'(1)) ? sms_pkg::ST_RD_A : sms_pkg::ST_ORD;
      end
      sms_pkg::ST_RD_A:  state_next = sms_pkg::ST_RD_B;
      sms_pkg::ST_RD_B:  state_next = sms_pkg::ST_MERGE;
      sms_pkg::ST_MERGE: if (pair_end) begin
        if (pass_end && (wid2 >= n_w)) begin
          state_next = sms_pkg::ST_ORD;
        end else begin
          state_next = sms_pkg::ST_RD_A;
        end
      end
      sms_pkg::ST_ORD:   state_next = sms_pkg::ST_OUT;
      sms_pkg::ST_OUT:   if (emit && (k + CW'(1) == n)) state_next = sms_pkg::ST_LOAD;
      default:           state_next = sms_pkg::ST_LOAD;
    endcase
  end

  // Memory ports and the queue take. Merging reads the source RAM and
  // writes the other one.
  always_comb begin
    cmd_take = 1'b0;
    st_we    = 1'b0;
    sc_we    = 1'b0;
    st_wa    = AW'(k);
    st_wd    = win;
    rd_addr  = AW'(k);
    unique case (state)
      sms_pkg::ST_LOAD: begin
        cmd_take = cmd_valid;
        st_we    = cmd_valid && cmd.keep;
        st_wa    = AW'(n);
        st_wd    = cmd.value;
      end
      sms_pkg::ST_RD_A:  rd_addr = AW'(a);
      sms_pkg::ST_RD_B:  rd_addr = AW'(b);
      sms_pkg::ST_MERGE: begin
        st_we   = src_sel;
        sc_we   = !src_sel;
        rd_addr = take_a ? AW'(a + CW'(1)) : AW'(b + CW'(1));
      end
      sms_pkg::ST_ORD:   rd_addr = '0;
      sms_pkg::ST_OUT:   rd_addr = emit ? AW'(k + CW'(1)) : AW'(k);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sms_pkg::ST_LOAD;
      n       <= '0;
      ovf     <= 1'b0;
      k       <= '0;
      src_sel <= 1'b0;
      ob_full <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        ob_full      <= 1'b1;
        sorted_value <= rd_data;
        last_out     <= (k + CW'(1) == n);
        overflow     <= ovf;
      end else if (pop) begin
        ob_full <= 1'b0;
      end
      unique case (state)
        sms_pkg::ST_LOAD: if (cmd_valid) begin
          n <= n_total;
          if (!cmd.keep) ovf <= 1'b1;
          if (cmd.is_last) begin
            wid     <= CW'(1);
            a       <= '0;
            b       <= CW'(1);
            mid     <= CW'(1);
            hi      <= CW'(2);
            k       <= '0;
            src_sel <= 1'b0;
          end
        end
        sms_pkg::ST_RD_B: begin
          va     <= rd_data;
          took_a <= 1'b0;
        end
        sms_pkg::ST_MERGE: begin
          va     <= cur_a;
          vb     <= cur_b;
          took_a <= take_a;
          if (!pair_end) begin
            k <= k + CW'(1);
            if (take_a) a <= a + CW'(1); else b <= b + CW'(1);
          end else if (!pass_end) begin
            a   <= hi;
            k   <= hi;
            mid <= nx_mid[CW-1:0];
            b   <= nx_mid[CW-1:0];
            hi  <= nx_hi[CW-1:0];
          end else begin
            src_sel <= !src_sel;
            wid     <= wid2[CW-1:0];
            a       <= '0;
            k       <= '0;
            mid     <= ps_mid[CW-1:0];
            b       <= ps_mid[CW-1:0];
            hi      <= ps_hi[CW-1:0];
          end
        end
        sms_pkg::ST_OUT: if (emit) begin
          if (k + CW'(1) == n) begin
            k   <= '0;
            n   <= '0;
            ovf <= 1'b0;
          end else begin
            k <= k + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (ob_full && !pop) |=> ob_full)
    else $error("result slot lost");
  assert property (@(posedge clk) disable iff (rst)
    (ob_full && !pop) |=> ($stable(sorted_value) && $stable(last_out) && $stable(overflow)))
    else $error("waiting result changed");
  assert property (@(posedge clk) disable iff (rst) (state == sms_pkg::ST_OUT) |-> (n != '0))
    else $error("emitting with no stored elements");
  assert property (@(posedge clk) disable iff (rst) cmd_take |-> (state == sms_pkg::ST_LOAD))
    else $error("request taken while sorting");
  assert property (@(posedge clk) disable iff (rst) (state == sms_pkg::ST_MERGE) |-> (k < hi))
    else $error("merge write past the run pair");

endmodule

// ===== sv/stable_merge_sorter.sv =====
// ----------------------------------------------------------------------------
// stable_merge_sorter: stable merge sort of up to MAX_ELEMENTS signed words
// Collects a run, merges bottom-up between two RAMs, then streams it sorted.
// ----------------------------------------------------------------------------
// After the last request of a run is accepted, the back end merges the run pairs
// pass by pass, fetching the two run heads before each pair, and then fetches
// the first result. Requests are taken one per cycle while loading, and results
// follow one per cycle while pop keeps up.
// Reset (rst, synchronous) empties the request queue, counters and result slot.
module stable_merge_sorter #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] value,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] sorted_value,
  output logic        last_out,
  output logic        overflow
);

  // The front end marks each request as kept or dropped and holds it in a
  // two-entry queue; the back end stores, sorts and streams the run. While
  // the back end sorts, the queue fills and full stalls the sender.
  logic          cmd_valid, cmd_take;
  sms_pkg::cmd_t cmd;

  sms_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .value(value), .last(last),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  // Each merge step compares the two run heads, writes the winner into the
  // other RAM and fetches the next head. Passes alternate between the store
  // and scratch RAMs.
  sms_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .empty(empty), .pop(pop), .sorted_value(sorted_value), .last_out(last_out),
    .overflow(overflow)
  );

endmodule
